// File: hw/rtl/crv_pkg.sv
package crv_pkg;

   localparam int unsigned DataWidth     = 32;
   localparam int unsigned MaxIterations = 28;
   localparam int unsigned StepWidth     = 5;
   localparam int unsigned CsrAddrWidth  = 3;
   localparam int unsigned CsrDataWidth  = 32;

   // register indexes
   localparam logic [0:0] REG_ITERATION_COUNT = 1'b0;

   localparam logic [StepWidth-1:0] IterationCountReset = StepWidth'(MaxIterations);

   // operation codes
   localparam logic OP_ROTATE = 1'b0;
   localparam logic OP_VECTOR = 1'b1;

   typedef logic signed [DataWidth-1:0] data_type;
   typedef logic [StepWidth-1:0]        step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } crv_state_type;

   // atan(2^-i) in Q3.28, rounded to nearest
   function automatic data_type atan_lookup(input step_type idx);
      data_type val;
      case (idx)
         5'd0:    val = 32'sd210828714;
         5'd1:    val = 32'sd124459457;
         5'd2:    val = 32'sd65760959;
         5'd3:    val = 32'sd33381290;
         5'd4:    val = 32'sd16755422;
         5'd5:    val = 32'sd8385879;
         5'd6:    val = 32'sd4193963;
         5'd7:    val = 32'sd2097109;
         5'd8:    val = 32'sd1048571;
         5'd9:    val = 32'sd524287;
         5'd10:   val = 32'sd262144;
         5'd11:   val = 32'sd131072;
         5'd12:   val = 32'sd65536;
         5'd13:   val = 32'sd32768;
         5'd14:   val = 32'sd16384;
         5'd15:   val = 32'sd8192;
         5'd16:   val = 32'sd4096;
         5'd17:   val = 32'sd2048;
         5'd18:   val = 32'sd1024;
         5'd19:   val = 32'sd512;
         5'd20:   val = 32'sd256;
         5'd21:   val = 32'sd128;
         5'd22:   val = 32'sd64;
         5'd23:   val = 32'sd32;
         5'd24:   val = 32'sd16;
         5'd25:   val = 32'sd8;
         5'd26:   val = 32'sd4;
         5'd27:   val = 32'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

   // add or subtract with clamping to the signed range
   function automatic data_type sat_addsub(input data_type a, input data_type b,
                                           input logic do_sub);
      logic signed [DataWidth:0] sum;
      data_type                  res;
      if (do_sub) begin
         sum = {a[DataWidth-1], a} - {b[DataWidth-1], b};
      end else begin
         sum = {a[DataWidth-1], a} + {b[DataWidth-1], b};
      end
      if (sum[DataWidth] != sum[DataWidth-1]) begin
         res = sum[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}}
                              : {1'b0, {(DataWidth-1){1'b1}}};
      end else begin
         res = sum[DataWidth-1:0];
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/crv_req_if.sv
interface crv_req_if
   import crv_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     operation;
   data_type x_in;
   data_type y_in;
   data_type z_in;

   modport source (output valid, output operation, output x_in, output y_in, output z_in,
                   input ready);
   modport sink (input valid, input operation, input x_in, input y_in, input z_in,
                 output ready);
endinterface

// File: hw/rtl/crv_rsp_if.sv
interface crv_rsp_if
   import crv_pkg::*;
();
   logic     valid;
   logic     ready;
   data_type x_out;
   data_type y_out;
   data_type z_out;

   modport source (output valid, output x_out, output y_out, output z_out, input ready);
   modport sink (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

// File: hw/rtl/circular_cordic_rotate_vector.sv
// the result becomes valid once n micro-rotations are done, n = min(iteration_count, 28)
// one vector at a time passes through the single shared
// shift/add unit that performs one micro-rotation per cycle
// the block takes no new vector until the result transfer completes
// reset (synchronous, active high) returns to idle and sets iteration_count to 28
module circular_cordic_rotate_vector
   import crv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   crv_req_if.sink                 req,
   crv_rsp_if.source               rsp,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   crv_state_type state_ff, state_in;
   step_type      iter_cnt_ff, iter_cnt_in;
   step_type      step_ff, step_in;
   step_type      limit_ff, limit_in;
   logic          mode_ff, mode_in;
   data_type      acc_x_ff, acc_x_in;
   data_type      acc_y_ff, acc_y_in;
   data_type      acc_z_ff, acc_z_in;

   logic          req_xfer;
   logic          rsp_xfer;
   logic          csr_write;
   logic          ccw;
   data_type      x_shift;
   data_type      y_shift;
   step_type      cnt_clamped;

   assign req_xfer  = req.valid && req.ready;
   assign rsp_xfer  = rsp.valid && rsp.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CsrAddrWidth-1] == REG_ITERATION_COUNT)
                       ? {{(CsrDataWidth-StepWidth){1'b0}}, iter_cnt_ff} : '0;

   always_comb begin
      iter_cnt_in = iter_cnt_ff;
      if (csr_write && (csr_paddr[CsrAddrWidth-1] == REG_ITERATION_COUNT)) begin
         iter_cnt_in = csr_pwdata[StepWidth-1:0];
      end
   end

   assign cnt_clamped = (iter_cnt_ff > step_type'(MaxIterations))
                        ? step_type'(MaxIterations) : iter_cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (step_ff == limit_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_xfer) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: req.ready = 1'b1;
         ST_DONE: rsp.valid = 1'b1;
         default: begin
            req.ready = 1'b0;
            rsp.valid = 1'b0;
         end
      endcase
   end

   assign rsp.x_out = acc_x_ff;
   assign rsp.y_out = acc_y_ff;
   assign rsp.z_out = acc_z_ff;

   // shared shift/add unit, one micro-rotation per cycle
   assign x_shift = acc_x_ff >>> step_ff;
   assign y_shift = acc_y_ff >>> step_ff;
   assign ccw     = (mode_ff == OP_VECTOR) ? acc_y_ff[DataWidth-1] : !acc_z_ff[DataWidth-1];

   always_comb begin
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      acc_z_in = acc_z_ff;
      step_in  = step_ff;
      limit_in = limit_ff;
      mode_in  = mode_ff;
      if (req_xfer) begin
         acc_x_in = req.x_in;
         acc_y_in = req.y_in;
         acc_z_in = req.z_in;
         mode_in  = req.operation;
         step_in  = '0;
         limit_in = cnt_clamped;
      end else if ((state_ff == ST_RUN) && (step_ff != limit_ff)) begin
         acc_x_in = sat_addsub(acc_x_ff, y_shift, ccw);
         acc_y_in = sat_addsub(acc_y_ff, x_shift, !ccw);
         acc_z_in = sat_addsub(acc_z_ff, atan_lookup(step_ff), ccw);
         step_in  = step_ff + step_type'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         iter_cnt_ff <= IterationCountReset;
      end else begin
         state_ff    <= state_in;
         iter_cnt_ff <= iter_cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      acc_z_ff <= acc_z_in;
      step_ff  <= step_in;
      limit_ff <= limit_in;
      mode_ff  <= mode_in;
   end

endmodule

// File: bench/circular_cordic_rotate_vector_tb.sv
`timescale 1ns / 100ps

module circular_cordic_rotate_vector_tb;
   import crv_pkg::*;

   // one set of final coordinates
   typedef struct packed {
      data_type x;
      data_type y;
      data_type z;
   } cordic_vec_type;

   // atan(2^-i) in Q3.28, rounded to nearest
   localparam data_type ATAN_Q28 [MaxIterations] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
      32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
      32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
      32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
      32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2
   };

   localparam data_type POS_FULL = 32'sh7fff_ffff;
   localparam data_type NEG_FULL = 32'sh8000_0000;
   localparam data_type ONE_Q28  = 32'sh1000_0000;

   logic clock;
   logic reset;

   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   crv_req_if req_bus ();
   crv_rsp_if rsp_bus ();

   cordic_vec_type expected_vectors[$];
   step_type       iteration_setting;
   bit             stall_enable;
   int unsigned    mismatch_count;

   circular_cordic_rotate_vector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // clamp a wide sum to the signed 32-bit range
   function automatic longint clamp_q28(input longint v);
      if (v > longint'(POS_FULL)) begin
         return longint'(POS_FULL);
      end
      if (v < longint'(NEG_FULL)) begin
         return longint'(NEG_FULL);
      end
      return v;
   endfunction

   // micro-rotations on x, y and z with the configured step count
   function automatic cordic_vec_type cordic_predict(input logic op, input data_type x_in,
                                                     input data_type y_in, input data_type z_in,
                                                     input step_type steps);
      longint         x;
      longint         y;
      longint         z;
      longint         x_shift;
      longint         y_shift;
      int unsigned    n;
      logic           ccw;
      cordic_vec_type res;
      x = longint'(x_in);
      y = longint'(y_in);
      z = longint'(z_in);
      n = (steps > MaxIterations) ? MaxIterations : steps;
      for (int i = 0; i < n; i++) begin
         x_shift = x >>> i;
         y_shift = y >>> i;
         ccw = (op == OP_VECTOR) ? (y < 0) : (z >= 0);
         if (ccw) begin
            x = clamp_q28(x - y_shift);
            y = clamp_q28(y + x_shift);
            z = clamp_q28(z - longint'(ATAN_Q28[i]));
         end else begin
            x = clamp_q28(x + y_shift);
            y = clamp_q28(y - x_shift);
            z = clamp_q28(z + longint'(ATAN_Q28[i]));
         end
      end
      res.x = data_type'(x);
      res.y = data_type'(y);
      res.z = data_type'(z);
      return res;
   endfunction

   // random coordinate: corners, full range or near the unit circle
   function automatic data_type pick_coord();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0:       return POS_FULL;
               1:       return NEG_FULL;
               2:       return '0;
               3:       return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1, 2, 3: return data_type'($urandom);
         default: return data_type'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      endcase
   endfunction

   // result side stalls
   always @(posedge clock) begin
      rsp_bus.ready <= !stall_enable || ($urandom_range(99) >= 33);
   end

   // result check against the oldest prediction
   always @(posedge clock) begin
      cordic_vec_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_vectors.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                     rsp_bus.x_out, rsp_bus.y_out, rsp_bus.z_out);
            mismatch_count++;
         end else begin
            want = expected_vectors.pop_front();
            if (rsp_bus.x_out !== want.x) begin
               $display("%0t: x_out expected %0d actual %0d", $time, want.x, rsp_bus.x_out);
               mismatch_count++;
            end
            if (rsp_bus.y_out !== want.y) begin
               $display("%0t: y_out expected %0d actual %0d", $time, want.y, rsp_bus.y_out);
               mismatch_count++;
            end
            if (rsp_bus.z_out !== want.z) begin
               $display("%0t: z_out expected %0d actual %0d", $time, want.z, rsp_bus.z_out);
               mismatch_count++;
            end
         end
      end
   end

   // one vector transfer, with random idle cycles ahead of it
   task automatic send_vector(input logic op, input data_type x_val, input data_type y_val,
                              input data_type z_val);
      while (stall_enable && $urandom_range(99) < 33) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.x_in      <= x_val;
      req_bus.y_in      <= y_val;
      req_bus.z_in      <= z_val;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      expected_vectors.push_back(cordic_predict(op, x_val, y_val, z_val, iteration_setting));
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_vectors.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // register write over the csr port, only with the engine idle
   task automatic write_iteration_count(input int unsigned value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrWidth'({REG_ITERATION_COUNT, 2'b00});
      csr_pwdata  <= CsrDataWidth'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      iteration_setting = step_type'(value);
   endtask

   // corners of the fields in both modes at the reset step count
   task automatic test_directed_extremes();
      send_vector(OP_ROTATE, ONE_Q28, '0, '0);
      send_vector(OP_ROTATE, ONE_Q28, '0, ATAN_Q28[0]);
      send_vector(OP_ROTATE, ONE_Q28, '0, -ATAN_Q28[0]);
      send_vector(OP_ROTATE, '0, '0, '0);
      send_vector(OP_ROTATE, -32'sd1, -32'sd1, -32'sd1);
      send_vector(OP_ROTATE, POS_FULL, POS_FULL, POS_FULL);
      send_vector(OP_ROTATE, NEG_FULL, NEG_FULL, NEG_FULL);
      send_vector(OP_ROTATE, POS_FULL, NEG_FULL, NEG_FULL);
      send_vector(OP_ROTATE, NEG_FULL, POS_FULL, POS_FULL);
      send_vector(OP_VECTOR, ONE_Q28, ONE_Q28, '0);
      send_vector(OP_VECTOR, ONE_Q28, -ONE_Q28, '0);
      send_vector(OP_VECTOR, '0, '0, '0);
      send_vector(OP_VECTOR, -32'sd1, -32'sd1, '0);
      send_vector(OP_VECTOR, POS_FULL, POS_FULL, '0);
      send_vector(OP_VECTOR, NEG_FULL, NEG_FULL, NEG_FULL);
      send_vector(OP_VECTOR, POS_FULL, NEG_FULL, POS_FULL);
      send_vector(OP_VECTOR, NEG_FULL, POS_FULL, NEG_FULL);
   endtask

   // zero steps pass the inputs through, counts above the table clamp
   task automatic test_iteration_counts();
      write_iteration_count(0);
      send_vector(OP_ROTATE, 32'sh1234_5678, -32'sh0765_4321, POS_FULL);
      send_vector(OP_VECTOR, NEG_FULL, POS_FULL, -32'sd1);
      write_iteration_count(1);
      send_vector(OP_ROTATE, ONE_Q28, ONE_Q28, -32'sd5);
      send_vector(OP_VECTOR, POS_FULL, -32'sd1, POS_FULL);
      write_iteration_count(31);
      send_vector(OP_ROTATE, ONE_Q28, '0, 32'sd100000000);
      send_vector(OP_VECTOR, -ONE_Q28, ONE_Q28, '0);
      write_iteration_count(29);
      send_vector(OP_VECTOR, ONE_Q28, 32'sd12345, '0);
   endtask

   // random vectors over a range of step counts
   task automatic test_random_vectors();
      int unsigned step_plan [10] = '{28, 1, 0, 31, 29, 2, 0, 28, 14, 27};
      int unsigned count_val;
      for (int p = 0; p < 10; p++) begin
         count_val = (p == 6) ? $urandom_range(31) : step_plan[p];
         write_iteration_count(count_val);
         // one phase runs with no idling on either side
         stall_enable = (p != 7);
         for (int k = 0; k < 160; k++) begin
            // sender holds off until the engine has emptied
            if (p == 3 && k == 80) begin
               wait_drained();
            end
            send_vector(logic'($urandom_range(1)), pick_coord(), pick_coord(), pick_coord());
         end
      end
      stall_enable = 1'b1;
   endtask

   // wait for the last results, then report
   task automatic finish_run();
      wait_drained();
      repeat (3 + MaxIterations + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_vectors.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   endtask

   // test sequence
   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_ROTATE;
      req_bus.x_in      <= '0;
      req_bus.y_in      <= '0;
      req_bus.z_in      <= '0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      stall_enable      = 1'b1;
      mismatch_count    = 0;
      iteration_setting = IterationCountReset;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_iteration_counts();
      test_random_vectors();
      finish_run();
   end

   // run time limit
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
